// ----- hw/rtl/rbb_pkg.sv -----
`default_nettype none

package rbb_pkg;

  localparam int PIXEL_BITS_DEF = 16;
  localparam int MAX_ROWS_DEF   = 8192;

  localparam int SAMPLE_W  = 16;
  localparam int ROW_W     = 13;
  localparam int FROWS_W   = 14;
  localparam int FINDEX_W  = 20;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;

  // row position divider: (u2 << 16) / hd, u2 below 2^28
  localparam int POS_DVD_W = 44;
  // 5 * 2^35: a multiple of 5 * 2^16 that lifts any phase product above zero
  localparam logic signed [POS_DVD_W-1:0] PH_OFFSET = 44'sd171798691840;
  // inverse of 5 modulo 2^16, for exact division by 5
  localparam logic [15:0] INV5_MOD16 = 16'hCCCD;

  localparam int EDGE_W = 17;
  localparam logic [EDGE_W-1:0] EDGE_FLOOR = 17'd7;
  localparam int SM_DVD_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_ROWS    = 3'd0,
    CFG_FRAME_INDEX   = 3'd1,
    CFG_BAND_HEIGHT   = 3'd2,
    CFG_ROLL_SPEED    = 3'd3,
    CFG_BAND_GAIN     = 3'd4,
    CFG_EDGE_SOFTNESS = 3'd5,
    CFG_WET_MIX       = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red;
    logic [SAMPLE_W-1:0] green;
    logic [SAMPLE_W-1:0] blue;
    logic [SAMPLE_W-1:0] alpha;
  } pix_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rbb_if.sv -----
`default_nettype none

interface rbb_in_if import rbb_pkg::*;;
  logic                valid;
  logic                ready;
  logic [ROW_W-1:0]    row_index;
  logic [SAMPLE_W-1:0] red_in;
  logic [SAMPLE_W-1:0] green_in;
  logic [SAMPLE_W-1:0] blue_in;
  logic [SAMPLE_W-1:0] alpha_in;

  modport source (output valid, row_index, red_in, green_in, blue_in, alpha_in,
                  input ready);
  modport sink (input valid, row_index, red_in, green_in, blue_in, alpha_in,
                output ready);
endinterface

interface rbb_out_if import rbb_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] red_out;
  logic [SAMPLE_W-1:0] green_out;
  logic [SAMPLE_W-1:0] blue_out;
  logic [SAMPLE_W-1:0] alpha_out;

  modport source (output valid, red_out, green_out, blue_out, alpha_out,
                  input ready);
  modport sink (input valid, red_out, green_out, blue_out, alpha_out,
                output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/rbb_div_pipe.sv -----
`default_nettype none

// Restoring divider, one quotient bit per stage. in_rem must be below in_div.
module rbb_div_pipe #(
  parameter int DW = 16,
  parameter int VW = 17,
  parameter int PW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [VW-1:0] in_rem,
  input  wire logic [DW-1:0] in_dvd,
  input  wire logic [VW-1:0] in_div,
  input  wire logic [PW-1:0] in_pay,
  output logic               out_valid,
  output logic [DW-1:0]      out_quo,
  output logic [PW-1:0]      out_pay
);

  logic [VW-1:0] rem_r   [DW];
  logic [VW-1:0] rem_nxt [DW];
  logic [DW-1:0] dvd_r   [DW];
  logic [DW-1:0] dvd_nxt [DW];
  logic [PW-1:0] pay_r   [DW];
  logic [VW-1:0] src_rem [DW];
  logic [DW-1:0] src_dvd [DW];
  logic [PW-1:0] src_pay [DW];
  logic [VW:0]   trial   [DW];
  logic [DW-1:0] vld_r;
  logic [DW-1:0] vld_nxt;

  always_comb begin
    src_rem[0] = in_rem;
    src_dvd[0] = in_dvd;
    src_pay[0] = in_pay;
    for (int k = 1; k < DW; k++) begin
      src_rem[k] = rem_r[k-1];
      src_dvd[k] = dvd_r[k-1];
      src_pay[k] = pay_r[k-1];
    end
    for (int k = 0; k < DW; k++) begin
      trial[k] = {src_rem[k], src_dvd[k][DW-1]};
      if (trial[k] >= {1'b0, in_div}) begin
        rem_nxt[k] = VW'(trial[k] - {1'b0, in_div});
        dvd_nxt[k] = {src_dvd[k][DW-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[k][VW-1:0];
        dvd_nxt[k] = {src_dvd[k][DW-2:0], 1'b0};
      end
    end
    vld_nxt = {vld_r[DW-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DW; k++) begin
        rem_r[k] <= rem_nxt[k];
        dvd_r[k] <= dvd_nxt[k];
        pay_r[k] <= src_pay[k];
      end
    end
  end

  assign out_valid = vld_r[DW-1];
  assign out_quo   = dvd_r[DW-1];
  assign out_pay   = pay_r[DW-1];

endmodule

`default_nettype wire

// ----- hw/rtl/rolling_band_brightness.sv -----
// Rolling band brightness: a soft horizontal band of changed brightness that
// rolls through the frame as frame_index advances.
// in_ch carries one pixel per transfer: its row counted from the bottom of the
// source and the four channel samples. out_ch carries the scaled RGB and the
// alpha sample. Both are valid/ready channels; a transfer happens on a rising
// clk edge with valid and ready high. One result per pixel, in order.
// The cfg port writes one register per cycle with cfg_we high; write it only
// while no pixel is in flight.
// Throughput: one pixel per cycle, sustained while out_ch takes its results.
// Most of the pipeline is the row position divider (44 one-bit stages) and
// the smoothstep edge dividers (16 stages). The roll phase comes from the
// registers alone.
// When out_ch stalls, the pipeline keeps moving until one more result sits in
// a skid register; then in_ch.ready drops and the whole pipeline holds.
// rst_n (synchronous, active low) empties the pipeline and loads the register
// reset values; no clearing pass is needed.
`default_nettype none

module rolling_band_brightness import rbb_pkg::*; #(
  parameter int PIXEL_BITS = PIXEL_BITS_DEF,
  parameter int MAX_ROWS   = MAX_ROWS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  rbb_in_if.sink                    in_ch,
  rbb_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam logic [19:0] FULL = 20'((1 << PIXEL_BITS) - 1);

  function automatic logic [SAMPLE_W-1:0] scale_sat(input logic [SAMPLE_W-1:0] c,
                                                     input logic [19:0] mult);
    logic [35:0] prod;
    logic [19:0] v;
    prod = 36'(c) * 36'(mult) + 36'd32768;
    v    = prod[35:16];
    return (v > FULL) ? SAMPLE_W'(FULL) : v[SAMPLE_W-1:0];
  endfunction

  // 16 is 1 mod 5, so folding the nibbles keeps the residue
  function automatic logic [2:0] mod5(input logic [7:0] s);
    logic [4:0] f;
    logic [4:0] r;
    f = 5'(s[7:4]) + 5'(s[3:0]);
    priority if (f >= 5'd25) r = f - 5'd25;
    else if (f >= 5'd20) r = f - 5'd20;
    else if (f >= 5'd15) r = f - 5'd15;
    else if (f >= 5'd10) r = f - 5'd10;
    else if (f >= 5'd5)  r = f - 5'd5;
    else                 r = f;
    return r[2:0];
  endfunction

  // configuration registers
  logic [FROWS_W-1:0]       frame_rows_r;
  logic [FINDEX_W-1:0]      frame_index_r;
  logic [15:0]              band_height_r;
  logic signed [15:0]       roll_speed_r;
  logic [15:0]              band_gain_r;
  logic [15:0]              edge_soft_r;
  logic [15:0]              wet_mix_r;
  logic [EDGE_W-1:0]        edge_r;
  logic [EDGE_W-1:0]        height_r;
  logic [31:0]              edge_prod;
  logic [EDGE_W-1:0]        edge_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_rows_r  <= 14'd1080;
      frame_index_r <= 20'd0;
      band_height_r <= 16'd9830;
      roll_speed_r  <= 16'sd1638;
      band_gain_r   <= 16'd11469;
      edge_soft_r   <= 16'd16384;
      wet_mix_r     <= 16'd32768;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_idx))
        CFG_FRAME_ROWS:    frame_rows_r  <= cfg_data[FROWS_W-1:0];
        CFG_FRAME_INDEX:   frame_index_r <= cfg_data[FINDEX_W-1:0];
        CFG_BAND_HEIGHT:   band_height_r <= cfg_data[15:0];
        CFG_ROLL_SPEED:    roll_speed_r  <= $signed(cfg_data[15:0]);
        CFG_BAND_GAIN:     band_gain_r   <= cfg_data[15:0];
        CFG_EDGE_SOFTNESS: edge_soft_r   <= cfg_data[15:0];
        CFG_WET_MIX:       wet_mix_r     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // edge width and band height follow the registers in the next cycle
  always_comb begin
    edge_prod = 32'(band_height_r) * 32'(edge_soft_r);
    edge_nxt  = edge_prod[31:15];
    if (edge_nxt < EDGE_FLOOR) edge_nxt = EDGE_FLOOR;
  end

  always_ff @(posedge clk) begin
    edge_r   <= edge_nxt;
    height_r <= {band_height_r, 1'b0};
  end

  // roll phase: floor(4 * speed * index / 5) mod 2^16, settles through ph_prod_r,
  // ph_sum_r/ph_lo_r and phase_r after a register write, long before a pixel needs it
  logic signed [36:0]          ph_prod_r;
  logic signed [POS_DVD_W-1:0] ph_lift;
  logic [7:0]                  ph_sum_nxt;
  logic [7:0]                  ph_sum_r;
  logic [15:0]                 ph_lo_r;
  logic [31:0]                 ph_mul;
  logic [15:0]                 phase_r;

  always_comb begin
    ph_lift    = (POS_DVD_W'(ph_prod_r) <<< 2) + PH_OFFSET;
    ph_sum_nxt = '0;
    for (int k = 0; k < POS_DVD_W / 4; k++) begin
      ph_sum_nxt = ph_sum_nxt + 8'(ph_lift[4*k +: 4]);
    end
    // drop the remainder, then divide exactly by 5
    ph_mul = 32'(ph_lo_r - 16'(mod5(ph_sum_r))) * 32'(INV5_MOD16);
  end

  always_ff @(posedge clk) begin
    ph_prod_r <= roll_speed_r * $signed({1'b0, frame_index_r});
    ph_sum_r  <= ph_sum_nxt;
    ph_lo_r   <= ph_lift[15:0];
    phase_r   <= ph_mul[15:0];
  end

  // pipeline control with output skid
  logic en;
  logic out_valid_r, skid_valid_r;
  pix_t out_r, skid_r;

  assign en          = !skid_valid_r;
  assign in_ch.ready = en;

  // stage A: input register
  logic             a_valid_r;
  logic [ROW_W-1:0] a_row_r;
  pix_t             a_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_valid_r <= 1'b0;
    else if (en) a_valid_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_row_r <= in_ch.row_index;
      a_pix_r <= '{red: in_ch.red_in, green: in_ch.green_in,
                   blue: in_ch.blue_in, alpha: in_ch.alpha_in};
    end
  end

  // stage B: lifted top-down row
  logic [FROWS_W-1:0] h, hd;
  logic [27:0]        u2_nxt;
  logic               b_valid_r;
  logic [27:0]        b_u2_r;
  pix_t               b_pix_r;

  always_comb begin
    h  = ({3'b0, frame_rows_r} > 17'(MAX_ROWS)) ? FROWS_W'(MAX_ROWS) : frame_rows_r;
    hd = (h == '0) ? FROWS_W'(1) : h;
    // adding hd * 8192 keeps the row non-negative without changing it mod hd
    u2_nxt = (28'(hd) << 13) + 28'(h) - 28'd1 - 28'(a_row_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_valid_r <= 1'b0;
    else if (en) b_valid_r <= a_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_u2_r  <= u2_nxt;
      b_pix_r <= a_pix_r;
    end
  end

  // row position divider
  logic                 rf_valid;
  logic [POS_DVD_W-1:0] rf_quo;
  pix_t                 rf_pay;

  rbb_div_pipe #(.DW(POS_DVD_W), .VW(FROWS_W), .PW(4*SAMPLE_W)) u_pos_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (b_valid_r),
    .in_rem   ('0),
    .in_dvd   ({b_u2_r, 16'b0}),
    .in_div   (hd),
    .in_pay   (b_pix_r),
    .out_valid(rf_valid),
    .out_quo  (rf_quo),
    .out_pay  (rf_pay)
  );

  // stage D: position within the band
  logic [15:0]       p;
  logic              d_valid_r, d_inband_r;
  logic [EDGE_W-1:0] d_xup_r, d_xdn_r;
  pix_t              d_pix_r;

  assign p = rf_quo[15:0] - phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_valid_r <= 1'b0;
    else if (en) d_valid_r <= rf_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_inband_r <= {1'b0, p} < height_r;
      d_xup_r    <= {1'b0, p};
      d_xdn_r    <= height_r - {1'b0, p};
      d_pix_r    <= rf_pay;
    end
  end

  // smoothstep ramps: x / edge, clamped at one
  logic                  up_cl, dn_cl;
  logic                  su_valid, sd_valid;
  logic [SM_DVD_W-1:0]   su_quo, sd_quo;
  logic [SAMPLE_W*4+1:0] su_pay;
  logic                  sd_pay;

  assign up_cl = d_xup_r >= edge_r;
  assign dn_cl = d_xdn_r >= edge_r;

  rbb_div_pipe #(.DW(SM_DVD_W), .VW(EDGE_W), .PW(SAMPLE_W*4+2)) u_up_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (d_valid_r),
    .in_rem   (up_cl ? '0 : d_xup_r),
    .in_dvd   ('0),
    .in_div   (edge_r),
    .in_pay   ({up_cl, d_inband_r, d_pix_r}),
    .out_valid(su_valid),
    .out_quo  (su_quo),
    .out_pay  (su_pay)
  );

  rbb_div_pipe #(.DW(SM_DVD_W), .VW(EDGE_W), .PW(1)) u_dn_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (d_valid_r),
    .in_rem   (dn_cl ? '0 : d_xdn_r),
    .in_dvd   ('0),
    .in_div   (edge_r),
    .in_pay   (dn_cl),
    .out_valid(sd_valid),
    .out_quo  (sd_quo),
    .out_pay  (sd_pay)
  );

  // stage E: t*t and 3 - 2t
  logic [16:0] t_up, t_dn;
  logic        e_valid_r, e_inband_r;
  logic [33:0] e_tt_up_r, e_tt_dn_r;
  logic [17:0] e_w_up_r, e_w_dn_r;
  pix_t        e_pix_r;

  assign t_up = su_pay[SAMPLE_W*4+1] ? 17'h10000 : {1'b0, su_quo};
  assign t_dn = sd_pay ? 17'h10000 : {1'b0, sd_quo};

  always_ff @(posedge clk) begin
    if (!rst_n) e_valid_r <= 1'b0;
    else if (en) e_valid_r <= su_valid & sd_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_tt_up_r  <= 34'(t_up) * 34'(t_up);
      e_tt_dn_r  <= 34'(t_dn) * 34'(t_dn);
      e_w_up_r   <= 18'd196608 - {t_up, 1'b0};
      e_w_dn_r   <= 18'd196608 - {t_dn, 1'b0};
      e_inband_r <= su_pay[SAMPLE_W*4];
      e_pix_r    <= su_pay[SAMPLE_W*4-1:0];
    end
  end

  // stage F: smoothstep values
  logic [51:0] s_up_prod, s_dn_prod;
  logic        f_valid_r, f_inband_r;
  logic [16:0] f_s_up_r, f_s_dn_r;
  pix_t        f_pix_r;

  assign s_up_prod = 52'(e_tt_up_r) * 52'(e_w_up_r);
  assign s_dn_prod = 52'(e_tt_dn_r) * 52'(e_w_dn_r);

  always_ff @(posedge clk) begin
    if (!rst_n) f_valid_r <= 1'b0;
    else if (en) f_valid_r <= e_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_s_up_r   <= s_up_prod[48:32];
      f_s_dn_r   <= s_dn_prod[48:32];
      f_inband_r <= e_inband_r;
      f_pix_r    <= e_pix_r;
    end
  end

  // stage G: band weight, zero outside the band
  logic [33:0] w_prod;
  logic        g_valid_r;
  logic [16:0] g_weight_r;
  pix_t        g_pix_r;

  assign w_prod = 34'(f_s_up_r) * 34'(f_s_dn_r);

  always_ff @(posedge clk) begin
    if (!rst_n) g_valid_r <= 1'b0;
    else if (en) g_valid_r <= f_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_weight_r <= f_inband_r ? w_prod[32:16] : '0;
      g_pix_r    <= f_pix_r;
    end
  end

  // stage H: gain times weight
  logic [32:0] d_prod;
  logic        h_valid_r;
  logic [17:0] h_delta_r;
  pix_t        h_pix_r;

  assign d_prod = 33'(band_gain_r) * 33'(g_weight_r);

  always_ff @(posedge clk) begin
    if (!rst_n) h_valid_r <= 1'b0;
    else if (en) h_valid_r <= g_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_delta_r <= d_prod[32:15];
      h_pix_r   <= g_pix_r;
    end
  end

  // stage I: wet blend
  logic [33:0] m_prod;
  logic        i_valid_r;
  logic [18:0] i_wet_r;
  pix_t        i_pix_r;

  assign m_prod = 34'(h_delta_r) * 34'(wet_mix_r);

  always_ff @(posedge clk) begin
    if (!rst_n) i_valid_r <= 1'b0;
    else if (en) i_valid_r <= h_valid_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_wet_r <= m_prod[33:15];
      i_pix_r <= h_pix_r;
    end
  end

  // final scale and saturate
  logic [19:0] mult;
  pix_t        res;

  always_comb begin
    mult      = 20'd65536 + {1'b0, i_wet_r};
    res.red   = scale_sat(i_pix_r.red, mult);
    res.green = scale_sat(i_pix_r.green, mult);
    res.blue  = scale_sat(i_pix_r.blue, mult);
    res.alpha = (20'(i_pix_r.alpha) > FULL) ? SAMPLE_W'(FULL) : i_pix_r.alpha;
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ch.ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= en && i_valid_r;
      end
    end else if (en && i_valid_r) begin
      // hold the result while the receiver stalls
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ch.ready || !out_valid_r) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (en && i_valid_r) begin
      skid_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = out_r.red;
  assign out_ch.green_out = out_r.green;
  assign out_ch.blue_out  = out_r.blue;
  assign out_ch.alpha_out = out_r.alpha;

endmodule

`default_nettype wire

// ----- test/tb_rolling_band_brightness.sv -----
`timescale 1ns / 100ps
`default_nettype none

module tb_rolling_band_brightness;
  import rbb_pkg::*;

  typedef struct {
    logic [ROW_W-1:0]    row;
    logic [SAMPLE_W-1:0] r, g, b, a;
  } pixel_t;

  typedef struct {
    logic [SAMPLE_W-1:0] r, g, b, a;
  } shaded_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_idx = CFG_FRAME_ROWS;
  logic [CFG_W-1:0] cfg_data = '0;

  rbb_in_if  in_ch();
  rbb_out_if out_ch();

  rolling_band_brightness u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow registers
  logic [13:0] sh_rows;
  logic [19:0] sh_findex;
  logic [15:0] sh_height, sh_gain, sh_soft, sh_mix;
  logic signed [15:0] sh_speed;

  pixel_t  pending_pixels[$];
  shaded_t shaded_expected[$];
  int errors = 0;
  int n_checked = 0;
  int n_sent = 0;
  bit hold_sink = 1'b0;
  bit start_hold = 1'b0;

  function automatic longint unsigned smooth_edge(longint unsigned x,
                                                   longint unsigned edge_w);
    longint unsigned t;
    t = (x * 65536) / edge_w;
    if (t > 65536) t = 65536;
    return (t * t * (3 * 65536 - 2 * t)) >> 32;
  endfunction

  function automatic logic [15:0] scale_clip(longint unsigned c, longint unsigned m);
    longint unsigned v;
    v = (c * m + 32768) >> 16;
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic shaded_t shade_pixel(pixel_t px);
    longint h, hd, ty, tm, m, mm;
    longint unsigned rowfrac, phase, p, height, edge_w, weight, delta, wet, mult;
    shaded_t s;
    h = (sh_rows > 8192) ? 8192 : longint'(sh_rows);
    hd = (h < 1) ? 1 : h;
    ty = h - 1 - longint'(px.row);
    tm = ((ty % hd) + hd) % hd;
    rowfrac = (tm * 65536) / hd;
    m = longint'(sh_speed) * longint'(sh_findex) * 4;
    mm = ((m % 327680) + 327680) % 327680;
    phase = (mm / 5) & 16'hFFFF;
    p = (rowfrac - phase) & 16'hFFFF;
    height = longint'(sh_height) * 2;
    edge_w = (longint'(sh_height) * longint'(sh_soft)) >> 15;
    if (edge_w < 7) edge_w = 7;
    weight = 0;
    if (p < height)
      weight = (smooth_edge(p, edge_w) * smooth_edge(height - p, edge_w)) >> 16;
    delta = (longint'(sh_gain) * weight) >> 15;
    wet = (delta * longint'(sh_mix)) >> 15;
    mult = 65536 + wet;
    s.r = scale_clip(px.r, mult);
    s.g = scale_clip(px.g, mult);
    s.b = scale_clip(px.b, mult);
    s.a = scale_clip(px.a, 65536);
    return s;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_checked);
  endtask

  // driver
  int src_gap = 0;
  initial begin
    in_ch.valid = 1'b0;
    in_ch.row_index = '0;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    in_ch.alpha_in = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      shaded_expected.insert(shaded_expected.size(),
                             shade_pixel(pending_pixels.pop_front()));
      n_sent++;
      src_gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) src_gap = 0;
    end
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (src_gap > 0 && !(in_ch.valid && !in_ch.ready)) begin
      src_gap--;
      in_ch.valid <= 1'b0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      // offer next pixel; queue front stays until transfer
      if (pending_pixels.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.row_index <= pending_pixels[0].row;
        in_ch.red_in <= pending_pixels[0].r;
        in_ch.green_in <= pending_pixels[0].g;
        in_ch.blue_in <= pending_pixels[0].b;
        in_ch.alpha_in <= pending_pixels[0].a;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver stall, counted here while the sender keeps offering
  initial begin
    wait (start_hold);
    hold_sink = 1'b1;
    repeat (400) @(posedge clk);
    hold_sink = 1'b0;
  end

  // monitor
  int sink_gap = 0;
  always @(posedge clk) begin
    shaded_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (shaded_expected.size() == 0) begin
        errors++;
        $display("unexpected result");
      end else begin
        want = shaded_expected.pop_front();
        if (out_ch.red_out !== want.r) report_mismatch("red", out_ch.red_out, want.r);
        if (out_ch.green_out !== want.g)
          report_mismatch("green", out_ch.green_out, want.g);
        if (out_ch.blue_out !== want.b) report_mismatch("blue", out_ch.blue_out, want.b);
        if (out_ch.alpha_out !== want.a)
          report_mismatch("alpha", out_ch.alpha_out, want.a);
      end
      n_checked++;
      sink_gap = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) sink_gap = 0;
    end
    if (!rst_n || hold_sink) begin
      out_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FRAME_ROWS:    sh_rows = val[13:0];
      CFG_FRAME_INDEX:   sh_findex = val[19:0];
      CFG_BAND_HEIGHT:   sh_height = val[15:0];
      CFG_ROLL_SPEED:    sh_speed = val[15:0];
      CFG_BAND_GAIN:     sh_gain = val[15:0];
      CFG_EDGE_SOFTNESS: sh_soft = val[15:0];
      CFG_WET_MIX:       sh_mix = val[15:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_pixels.size() > 0 || shaded_expected.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic add_pixel(logic [ROW_W-1:0] row, logic [15:0] r, logic [15:0] g,
                           logic [15:0] b, logic [15:0] a);
    pixel_t px;
    px.row = row; px.r = r; px.g = g; px.b = b; px.a = a;
    pending_pixels.insert(pending_pixels.size(), px);
  endtask

  task automatic add_random(int n, int rows);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0)
        add_pixel(ROW_W'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
      else
        add_pixel(ROW_W'($urandom_range(0, (rows > 0 ? rows : 1) - 1)), 16'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic random_config();
    write_reg(CFG_FRAME_ROWS, ($urandom_range(0, 7) == 0) ? 20'($urandom_range(0, 16383))
                                                         : 20'($urandom_range(1, 8192)));
    write_reg(CFG_FRAME_INDEX, 20'($urandom_range(0, 1048575)));
    write_reg(CFG_BAND_HEIGHT, 20'($urandom_range(1638, 32768)));
    write_reg(CFG_ROLL_SPEED, 20'(16'($urandom_range(0, 32768) - 16384)));
    write_reg(CFG_BAND_GAIN, 20'($urandom_range(0, 32768)));
    write_reg(CFG_EDGE_SOFTNESS, 20'($urandom_range(0, 32768)));
    write_reg(CFG_WET_MIX, 20'($urandom_range(0, 32768)));
  endtask

  initial begin
    sh_rows = 1080; sh_findex = 0; sh_height = 9830; sh_speed = 1638;
    sh_gain = 11469; sh_soft = 16384; sh_mix = 32768;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // reset values, row extremes and sample extremes
    add_pixel(0, 0, 0, 0, 0);
    add_pixel(1079, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    add_pixel(8191, 16'h8000, 16'h7FFF, 16'h1234, 16'hFFFF);
    for (int i = 0; i < 8; i++)
      add_pixel(ROW_W'(1079 - i * 25), 16'hFFFF, 16'hC000, 16'h0001, 16'h0000);
    drain();
    // zero rows, large gain, no feather
    write_reg(CFG_FRAME_ROWS, 0);
    write_reg(CFG_EDGE_SOFTNESS, 0);
    write_reg(CFG_BAND_GAIN, 32768);
    add_pixel(0, 16'hFFFF, 16'h8000, 1, 2);
    add_pixel(8191, 16'hF000, 16'h8000, 1, 2);
    drain();
    // rows above max, extreme speed and index, beyond-range registers
    write_reg(CFG_FRAME_ROWS, 16383);
    write_reg(CFG_FRAME_INDEX, 1048575);
    write_reg(CFG_ROLL_SPEED, 20'hF8000);
    write_reg(CFG_BAND_HEIGHT, 20'hFFFF);
    write_reg(CFG_EDGE_SOFTNESS, 20'hFFFF);
    write_reg(CFG_WET_MIX, 20'hFFFF);
    write_reg(CFG_BAND_GAIN, 20'hFFFF);
    for (int i = 0; i < 6; i++)
      add_pixel(ROW_W'(i * 1500), 16'hFFFF, 16'h4000, 16'h0100, 16'hAAAA);
    drain();
    write_reg(CFG_ROLL_SPEED, 16384);
    write_reg(CFG_BAND_HEIGHT, 1638);
    write_reg(CFG_WET_MIX, 0);
    write_reg(CFG_FRAME_ROWS, 1);
    add_pixel(0, 16'h5555, 16'hAAAA, 16'hFFFF, 16'h0);
    add_pixel(5, 16'h5555, 16'hAAAA, 16'hFFFF, 16'h0);
    drain();
    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      random_config();
      add_random(120, int'(sh_rows));
      if (ph == 3) begin
        // long receiver stall while the sender keeps offering
        start_hold = 1'b1;
      end
      drain();
    end
    $display("sent %0d pixels, checked %0d results over 16 register settings",
             n_sent, n_checked);
    $display("included zero/oversized frame rows, both roll directions, long stall");
    if (errors == 0) begin
      $display("** rolling_band_brightness: PASSED **");
    end else begin
      $display("** rolling_band_brightness: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** rolling_band_brightness: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
